// ----- design/mmm_pkg.sv -----
// Shared types and constants of the multichannel moving median filter.
`default_nettype none

package mmm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int CHANNEL_W  = 3;
   localparam int LEN_W      = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Word index of the window length register on the configuration port.
   localparam logic REG_WINDOW_LEN = 1'b0;

   localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 4'd5;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
   } cell_state_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } sort_ctrl_type;

endpackage

`default_nettype wire

// ----- design/multichannel_moving_median_top.sv -----
// Top level of the multichannel moving median filter.
//
//  Port group  Direction  Transfer contents
//  req_*       in         tuser: channel; tdata: sample
//  rsp_*       out        tdata: median; tuser: rejected
//  csr_*       in/out     window length register at byte address 0
//
// An accepted sample is written to the ring; then one RAM read is made per
// window entry (S_READ), the last entry is inserted into the sorting chain
// (S_DRAIN) and the output register is loaded once it is free (S_FINISH).
// A rejected item skips to S_FINISH. The next item may enter while a result waits.
// Reset is synchronous; the ring entries read as zero until first written.
`default_nettype none

module multichannel_moving_median_top #(
   parameter int CHANNELS     = 4,
   parameter int WINDOW_SLOTS = 11
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input stream.
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [15:0]                        req_tdata,  // [15:0] sample
   input  wire logic [2:0]                         req_tuser,  // [2:0] channel
   // Result stream.
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [15:0]                        rsp_tdata,  // [15:0] median
   output      logic                               rsp_tuser,  // [0] rejected
   // Configuration port.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mmm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [mmm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [mmm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                               csr_pready
);

   localparam int ENTRIES  = CHANNELS * WINDOW_SLOTS;
   localparam int ADDR_W   = $clog2(ENTRIES);
   localparam int CELLS    = WINDOW_SLOTS - 1;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHX_W    = (CH_IDX_W > mmm_pkg::CHANNEL_W) ? CH_IDX_W : mmm_pkg::CHANNEL_W;
   localparam int POS_W    = $clog2(WINDOW_SLOTS);
   localparam int CMP_W    = ((POS_W > mmm_pkg::LEN_W) ? POS_W : mmm_pkg::LEN_W) + 1;
   localparam int SEL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SELX_W   = (SEL_W > mmm_pkg::LEN_W) ? SEL_W : mmm_pkg::LEN_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type                           state_ff;
   logic [mmm_pkg::LEN_W-1:0]           window_len_ff;
   logic [mmm_pkg::LEN_W-1:0]           len_ff;
   logic [mmm_pkg::LEN_W-1:0]           k_ff;
   logic [ADDR_W-1:0]                   base_ff;
   logic                                rej_ff;
   logic                                ins_ff;
   logic                                rd_valid_ff;
   logic                                rsp_tvalid_ff;
   logic [15:0]                         rsp_tdata_ff;
   logic                                rsp_tuser_ff;
   logic [POS_W-1:0]                    position_ff [CHANNELS];
   logic [ENTRIES-1:0]                  written_ff;

   logic                                req_xfer;
   logic                                reject;
   logic [CHX_W-1:0]                    ch_wide;
   logic [CH_IDX_W-1:0]                 ch_idx;
   logic [CMP_W-1:0]                    pos_wide;
   logic [POS_W-1:0]                    pos_new;
   logic [ADDR_W-1:0]                   base_new;
   logic [ADDR_W-1:0]                   wr_addr;
   logic [ADDR_W-1:0]                   rd_addr;
   logic                                rd_en;
   logic [15:0]                         rd_data;
   logic signed [mmm_pkg::SAMPLE_W-1:0] ins_value;
   mmm_pkg::sort_ctrl_type              sort_ctrl;
   mmm_pkg::cell_state_type             cells [CELLS];
   logic [CELLS-1:0]                    cell_valid;
   logic [SELX_W-1:0]                   sel_wide;
   logic [SEL_W-1:0]                    sel_idx;
   logic                                out_free;
   logic                                csr_write;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= mmm_pkg::WINDOW_LEN_RESET;
      end else if (csr_write && (csr_paddr[2] == mmm_pkg::REG_WINDOW_LEN)) begin
         window_len_ff <= csr_pwdata[mmm_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == mmm_pkg::REG_WINDOW_LEN) begin
         csr_prdata = mmm_pkg::CSR_DATA_W'(window_len_ff);
      end
   end

   // Input decode and ring position update.
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign ch_wide    = CHX_W'(req_tuser);
   assign ch_idx     = ch_wide[CH_IDX_W-1:0];
   assign reject     = (32'(req_tuser) >= 32'(CHANNELS)) || (window_len_ff == '0) ||
                       (32'(window_len_ff) >= 32'(WINDOW_SLOTS));

   always_comb begin
      pos_wide = CMP_W'(position_ff[ch_idx]) + CMP_W'(1);
      if (pos_wide >= CMP_W'(window_len_ff)) begin
         pos_wide = '0;
      end
      pos_new = pos_wide[POS_W-1:0];
   end

   assign base_new = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_SLOTS);
   assign wr_addr  = base_new + ADDR_W'(pos_new);
   assign rd_en    = (state_ff == S_READ);
   assign rd_addr  = base_ff + ADDR_W'(k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            position_ff[c] <= '0;
         end
         written_ff <= '0;
      end else if (req_xfer && !reject) begin
         position_ff[ch_idx] <= pos_new;
         written_ff[wr_addr] <= 1'b1;
      end
   end

   mmm_ram #(
      .WIDTH (mmm_pkg::SAMPLE_W),
      .DEPTH (ENTRIES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_xfer && !reject),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= written_ff[rd_addr];
      end
   end

   // Entries never written since reset take part as zeros.
   assign ins_value        = rd_valid_ff ? $signed(rd_data) : '0;
   assign sort_ctrl.clear  = req_xfer;
   assign sort_ctrl.insert = ins_ff;

   mmm_sorter #(
      .CELLS (CELLS)
   ) u_sorter (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sort_ctrl),
      .ins_value (ins_value),
      .cells     (cells)
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_valid
      assign cell_valid[i] = cells[i].valid;
   end

   assign sel_wide = SELX_W'(len_ff >> 1);
   assign sel_idx  = sel_wide[SEL_W-1:0];
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ins_ff        <= 1'b0;
         rej_ff        <= 1'b0;
         k_ff          <= '0;
         len_ff        <= '0;
         base_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // In S_FINISH the output register is reloaded whenever it is free.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               ins_ff <= 1'b0;
               if (req_xfer) begin
                  rej_ff  <= reject;
                  len_ff  <= window_len_ff;
                  base_ff <= base_new;
                  k_ff    <= '0;
                  state_ff <= reject ? S_FINISH : S_READ;
               end
            end
            S_READ: begin
               ins_ff <= 1'b1;
               k_ff   <= k_ff + 1'b1;
               if (k_ff == len_ff - 1'b1) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               ins_ff   <= 1'b0;
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= rej_ff ? '0 : cells[sel_idx].value;
                  rsp_tuser_ff  <= rej_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef ASSERT_OFF
   a_read_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (k_ff < len_ff))
      else $error("read index past the window length");

   a_reject_skips_read: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && reject) |=> (state_ff == S_FINISH))
      else $error("rejected item entered the read sweep");

   a_chain_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && !rej_ff) |->
         (32'($countones(cell_valid)) == 32'(len_ff)))
      else $error("sorting chain does not hold the whole window");

   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !reject) |-> (CMP_W'(pos_new) < CMP_W'(window_len_ff)))
      else $error("write position outside the window");
`endif

endmodule

`default_nettype wire

// ----- design/mmm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 44
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/mmm_sort_cell.sv -----
// One cell of the insertion sorting chain: holds one ordered entry.
`default_nettype none

module mmm_sort_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mmm_pkg::sort_ctrl_type             ctrl,
   input  wire logic signed [mmm_pkg::SAMPLE_W-1:0] ins_value,
   input  wire mmm_pkg::cell_state_type            left_state,
   input  wire logic                               left_lt,
   output      mmm_pkg::cell_state_type            state,
   output      logic                               lt
);

   logic                               valid_ff;
   logic                               valid_in;
   logic signed [mmm_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [mmm_pkg::SAMPLE_W-1:0] value_in;

   // An empty cell counts as larger than any sample.
   assign lt = !valid_ff || (ins_value < value_ff);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert && lt) begin
         if (left_lt) begin
            // The new value lands further left, so this cell takes its neighbor's entry.
            valid_in = left_state.valid;
            value_in = left_state.value;
         end else begin
            valid_in = 1'b1;
            value_in = ins_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign state.valid = valid_ff;
   assign state.value = value_ff;

endmodule

`default_nettype wire

// ----- design/mmm_sorter.sv -----
// Chain of sorting cells that orders the window one sample per cycle.
`default_nettype none

module mmm_sorter #(
   parameter int CELLS = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mmm_pkg::sort_ctrl_type             ctrl,
   input  wire logic signed [mmm_pkg::SAMPLE_W-1:0] ins_value,
   output      mmm_pkg::cell_state_type            cells [CELLS]
);

   logic                    lt_vec [CELLS];
   mmm_pkg::cell_state_type left_vec [CELLS];
   logic                    left_lt_vec [CELLS];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_vec[i]    = '0;
         assign left_lt_vec[i] = 1'b0;
      end else begin : g_body
         assign left_vec[i]    = cells[i-1];
         assign left_lt_vec[i] = lt_vec[i-1];
      end

      mmm_sort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .ins_value  (ins_value),
         .left_state (left_vec[i]),
         .left_lt    (left_lt_vec[i]),
         .state      (cells[i]),
         .lt         (lt_vec[i])
      );
   end

endmodule

`default_nettype wire

// ----- tb/median_scoreboard_pkg.sv -----
// Scoreboard for the moving median testbench: predicts each median and checks the results.
package median_scoreboard_pkg;
   import mmm_pkg::*;

   localparam int FILTER_CHANNELS = 4;
   localparam int RING_SLOTS      = 11;
   localparam int REPORT_LIMIT    = 10;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type median;
      logic       rejected;
   } median_result_type;

   class median_tracker;
      sample_type        ring[FILTER_CHANNELS][RING_SLOTS];
      logic [LEN_W-1:0]  slot[FILTER_CHANNELS];
      logic [LEN_W-1:0]  window_len;
      median_result_type expected_medians[$];
      int                mismatches;

      function new();
         window_len = WINDOW_LEN_RESET;
         mismatches = 0;
         for (int c = 0; c < FILTER_CHANNELS; c++) begin
            slot[c] = '0;
            for (int k = 0; k < RING_SLOTS; k++) begin
               ring[c][k] = '0;
            end
         end
      endfunction

      function void report(string text);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t mismatch: %s", $time, text);
         end
      endfunction

      function void set_window_len(logic [LEN_W-1:0] value);
         window_len = value;
      endfunction

      function void check_window_len(logic [LEN_W-1:0] seen);
         if (seen !== window_len) begin
            report($sformatf("window_len read %0d, expected %0d", seen, window_len));
         end
      endfunction

      // Called for every input transfer; queues the result the filter must give for it.
      function void note_sample(logic [CHANNEL_W-1:0] channel, sample_type sample);
         sample_type        sorted[RING_SLOTS];
         sample_type        pick;
         median_result_type outcome;
         int                next_slot;
         int                j;
         if (channel >= FILTER_CHANNELS || window_len == 0 || window_len >= RING_SLOTS) begin
            outcome.median   = '0;
            outcome.rejected = 1'b1;
         end else begin
            // The slot wraps also when a shortened window leaves it beyond the new length.
            next_slot = int'(slot[channel]) + 1;
            if (next_slot >= window_len) begin
               next_slot = 0;
            end
            slot[channel] = LEN_W'(next_slot);
            ring[channel][next_slot] = sample;
            for (int i = 0; i < window_len; i++) begin
               sorted[i] = ring[channel][i];
            end
            for (int i = 1; i < window_len; i++) begin
               pick = sorted[i];
               j = i;
               while (j > 0 && sorted[j-1] > pick) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = pick;
            end
            outcome.median   = sorted[window_len / 2];
            outcome.rejected = 1'b0;
         end
         expected_medians.push_back(outcome);
      endfunction

      function void check_median(sample_type median, logic rejected);
         median_result_type want;
         if (expected_medians.size() == 0) begin
            report($sformatf("unexpected result: median %0d rejected %0b", median, rejected));
         end else begin
            want = expected_medians.pop_front();
            if (want.median !== median || want.rejected !== rejected) begin
               report($sformatf("median %0d rejected %0b, expected median %0d rejected %0b",
                                median, rejected, want.median, want.rejected));
            end
         end
      endfunction

      function void flag_leftovers();
         median_result_type want;
         while (expected_medians.size() != 0) begin
            want = expected_medians.pop_front();
            report($sformatf("missing result: median %0d rejected %0b",
                             want.median, want.rejected));
         end
      endfunction
   endclass

endpackage

// ----- tb/multichannel_moving_median_top_test.sv -----
// Testbench top of the multichannel moving median filter.
module multichannel_moving_median_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mmm_pkg::*;
   import median_scoreboard_pkg::*;

   // The longest quiet stretch of a correct run is the receiver hold plus one item.
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_PERCENT = 13;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_LEN_ADDR = CSR_ADDR_W'({REG_WINDOW_LEN, 2'b00});

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata   = '0;
   logic [2:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic idle_enabled  = 1'b1;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;

   median_tracker tracker = new();

   multichannel_moving_median_top #(
      .CHANNELS     (FILTER_CHANNELS),
      .WINDOW_SLOTS (RING_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Results are checked before the same edge's input is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_median(rsp_tdata, rsp_tuser);
         end
         if (req_tvalid && req_tready) begin
            tracker.note_sample(req_tuser, req_tdata);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == WINDOW_LEN_ADDR) begin
            tracker.set_window_len(csr_pwdata[LEN_W-1:0]);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stalls, plus a long hold each time the stimulus asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= !(idle_enabled && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Valid stays high after the transfer so that the next item can follow directly.
   task automatic send_sample(logic [2:0] channel, logic [15:0] sample);
      req_tuser  <= channel;
      req_tdata  <= sample;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic sender_gap();
      if (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_medians.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [LEN_W-1:0] value,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= WINDOW_LEN_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes the window length, then reads it back.
   task automatic set_window_len(logic [LEN_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b1, value, readback);
      @(posedge clock);
      csr_access(1'b0, '0, readback);
      tracker.check_window_len(readback[LEN_W-1:0]);
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] readback;
      logic [LEN_W-1:0]      len;
      logic [2:0]            channel;
      logic [15:0]           sample;
      int                    sent;
      int                    phase;
      int                    count;
      int                    pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0, readback);
      tracker.check_window_len(readback[LEN_W-1:0]);
      @(posedge clock);

      // Reset window of five: unwritten ring entries still count as zeros.
      send_sample(3'd0, 16'h7FFF);
      send_sample(3'd0, 16'h8000);
      send_sample(3'd0, 16'd100);
      send_sample(3'd0, 16'd200);
      send_sample(3'd0, 16'hFFFF);
      send_sample(3'd3, 16'h7FFF);
      send_sample(3'd1, 16'hFFFF);
      send_sample(3'd2, 16'h5A5A);
      send_sample(3'd4, 16'd1);
      send_sample(3'd7, 16'h8000);
      wait_drained();
      set_window_len(4'd10);
      send_sample(3'd0, 16'hA5A5);
      send_sample(3'd0, 16'd3);
      send_sample(3'd2, 16'h8000);
      wait_drained();
      // Shortening the window leaves channel zero's slot on the last entry of the new window.
      set_window_len(4'd3);
      send_sample(3'd0, 16'd7);
      send_sample(3'd0, 16'hFFF9);
      wait_drained();
      set_window_len(4'd1);
      send_sample(3'd1, 16'h8000);
      wait_drained();
      set_window_len(4'd2);
      send_sample(3'd2, 16'd5);
      send_sample(3'd2, 16'd9);
      wait_drained();
      set_window_len(4'd0);
      send_sample(3'd0, 16'd1);
      wait_drained();
      set_window_len(4'd11);
      send_sample(3'd1, 16'd1);
      wait_drained();
      set_window_len(4'd15);
      send_sample(3'd3, 16'hFFFF);
      wait_drained();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            len = '0;
         end else if (pick < 10) begin
            len = LEN_W'($urandom_range(15, 11));
         end else begin
            len = LEN_W'($urandom_range(10, 1));
         end
         if (len == 0 || len > 10) begin
            count = 8;
         end else begin
            count = $urandom_range(70, 30);
         end
         if (phase == 1 || phase == 5) begin
            count = 60;
            hold_requests <= hold_requests + 1;
         end
         if (phase == 2) begin
            // A long run with a valid window length for the phase without idling.
            len   = LEN_W'($urandom_range(10, 1));
            count = 80;
         end
         set_window_len(len);
         // One phase runs with neither side idling.
         idle_enabled <= (phase != 2);
         for (int i = 0; i < count; i++) begin
            if (phase == 3 && i == count / 2) begin
               wait_drained();
            end
            sender_gap();
            channel = ($urandom_range(99) < 90) ? 3'($urandom_range(3, 0))
                                                : 3'($urandom_range(7, 4));
            pick = $urandom_range(99);
            if (pick < 10) begin
               case ($urandom_range(3, 0))
                  0:       sample = 16'h8000;
                  1:       sample = 16'h7FFF;
                  2:       sample = 16'h0000;
                  default: sample = 16'hFFFF;
               endcase
            end else if (pick < 40) begin
               // A narrow range makes ties in the window common.
               sample = 16'($signed($urandom_range(8, 0)) - 4);
            end else begin
               sample = 16'($urandom());
            end
            send_sample(channel, sample);
            sent++;
         end
         wait_drained();
         phase++;
      end

      repeat (16) @(posedge clock);
      tracker.flag_leftovers();
      if (tracker.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/mmm_pkg.sv
design/mmm_ram.sv
design/mmm_sort_cell.sv
design/mmm_sorter.sv
design/multichannel_moving_median_top.sv
tb/median_scoreboard_pkg.sv
tb/multichannel_moving_median_top_test.sv
